/* rtl/wsd_pkg.sv */
// Package for the websocket frame deframer.
// Holds the parse phase type, opcode and length codes, and the result struct.
// No dependencies.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [6:0] LEN_EXT64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic       valid;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       close_seen;
  } result_t;

endpackage

/* rtl/wsd_parser.sv */
// Frame header parser and payload unmasker of the websocket frame deframer.
// Updates the parse state for one byte per enabled cycle and forms its result.
// Depends on wsd_pkg.
module wsd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       byte_i,
  output wsd_pkg::result_t res_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        final_q, final_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;

  logic [6:0]  len7;
  logic [63:0] rem_shift;
  logic [7:0]  key_byte;
  logic        is_text, is_close, cnt_last, rem_last;

  assign len7      = byte_i[6:0];
  assign rem_shift = {rem_q[55:0], byte_i};
  assign is_text   = final_q && (opcode_q == wsd_pkg::OPC_TEXT);
  assign is_close  = final_q && (opcode_q == wsd_pkg::OPC_CLOSE);
  assign cnt_last  = (cnt_q == 4'd1);
  assign rem_last  = (rem_q == 64'd1);

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    final_d  = final_q;
    opcode_d = opcode_q;
    masked_d = masked_q;
    rem_d    = rem_q;
    key_d    = key_q;
    idx_d    = idx_q;
    case (phase_q)
      wsd_pkg::PH_HDR1: begin
        masked_d = byte_i[7];
        if (len7 == wsd_pkg::LEN_EXT16) begin
          rem_d   = '0;
          phase_d = wsd_pkg::PH_EXTLEN;
          cnt_d   = wsd_pkg::EXT16_BYTES;
        end else if (len7 == wsd_pkg::LEN_EXT64) begin
          rem_d   = '0;
          phase_d = wsd_pkg::PH_EXTLEN;
          cnt_d   = wsd_pkg::EXT64_BYTES;
        end else begin
          rem_d = {57'd0, len7};
          if (byte_i[7]) begin
            phase_d = wsd_pkg::PH_MASK;
            cnt_d   = wsd_pkg::KEY_BYTES;
          end else begin
            idx_d   = 2'd0;
            phase_d = (len7 == 7'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        rem_d = rem_shift;
        cnt_d = cnt_q - 4'd1;
        if (cnt_last) begin
          if (masked_q) begin
            phase_d = wsd_pkg::PH_MASK;
            cnt_d   = wsd_pkg::KEY_BYTES;
          end else begin
            idx_d   = 2'd0;
            phase_d = (rem_shift == 64'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsd_pkg::PH_MASK: begin
        key_d = {key_q[23:0], byte_i};
        cnt_d = cnt_q - 4'd1;
        if (cnt_last) begin
          idx_d   = 2'd0;
          phase_d = (rem_q == 64'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        rem_d = rem_q - 64'd1;
        idx_d = idx_q + 2'd1;
        if (rem_last) phase_d = wsd_pkg::PH_HDR0;
      end
      default: begin
        final_d  = byte_i[7];
        opcode_d = byte_i[3:0];
        masked_d = 1'b0;
        rem_d    = '0;
        key_d    = '0;
        idx_d    = 2'd0;
        cnt_d    = 4'd0;
        phase_d  = wsd_pkg::PH_HDR1;
      end
    endcase
  end

  // Result
  always_comb begin
    logic done;
    done  = 1'b0;
    res_o = '0;
    case (phase_q)
      wsd_pkg::PH_HDR1:
        done = (len7 == 7'd0) && !byte_i[7];
      wsd_pkg::PH_EXTLEN:
        done = cnt_last && !masked_q && (rem_shift == 64'd0);
      wsd_pkg::PH_MASK:
        done = cnt_last && (rem_q == 64'd0);
      wsd_pkg::PH_PAYLOAD: begin
        if (is_text) begin
          res_o.valid      = 1'b1;
          res_o.text_byte  = byte_i ^ key_byte;
          res_o.byte_valid = 1'b1;
          res_o.frame_end  = rem_last;
        end else begin
          done = rem_last;
        end
      end
      default: done = 1'b0;
    endcase
    // End marker for text, indication for close
    if (done && (is_text || is_close)) begin
      res_o.valid      = 1'b1;
      res_o.frame_end  = 1'b1;
      res_o.close_seen = is_close;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsd_pkg::PH_HDR0;
      cnt_q    <= '0;
      final_q  <= 1'b0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      rem_q    <= '0;
      key_q    <= '0;
      idx_q    <= '0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      final_q  <= final_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
    end
  end

endmodule

/* rtl/wsd_out_reg.sv */
// Result register of the websocket frame deframer.
// Holds one result until the receiver takes it. Depends on wsd_pkg.
module wsd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wsd_pkg::result_t res_i,
  input  logic             stall_i,
  output logic             valid_o,
  output wsd_pkg::result_t res_o
);

  logic             valid_q;
  wsd_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_i.valid;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* rtl/websocket_frame_deframer.sv */
// Top level of the websocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_parser and wsd_out_reg.
//
// Usage:
//   The rx channel (rx_valid_i, rx_stall_o, rx_byte_i) takes one stream byte per
//   transfer. The out channel (out_valid_o, out_stall_i and the result fields)
//   gives the unmasked payload bytes of final text frames, with frame_end_o on
//   the frame's last byte, an end marker (byte_valid_o low) for an empty text
//   frame, and a close indication for a completed final close frame. All other
//   frames are consumed with no transfer on the out channel.
//   Throughput: one byte per cycle, sustained, as long as out_stall_i is low.
//   Path: the byte of a transfer is held in the input register, then passes through
//   the parser into the result register, which shows the result it causes. The
//   64-bit length counter update and zero check set the parser's path.
//   Reset: clears all handshake state and the parser, which then expects the
//   first header byte of a frame.
//   Stall: while out_stall_i holds a waiting result, the input register keeps one
//   more byte and rx_stall_o rises once it is full; no byte is lost or parsed twice.
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] text_byte_o,
  output logic       byte_valid_o,
  output logic       frame_end_o,
  output logic       close_seen_o
);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             rx_take, advance;
  wsd_pkg::result_t parse_res, out_res;

  // Advance the held byte into the parser when the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign rx_stall_o = in_valid_q && !advance;
  assign rx_take    = rx_valid_i && !rx_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_take)      in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Hold the byte of the last transfer
  always_ff @(posedge clk_i) begin
    if (rx_take) in_byte_q <= rx_byte_i;
  end

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .byte_i (in_byte_q),
    .res_o  (parse_res)
  );

  wsd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (parse_res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign text_byte_o  = out_res.text_byte;
  assign byte_valid_o = out_res.byte_valid;
  assign frame_end_o  = out_res.frame_end;
  assign close_seen_o = out_res.close_seen;

endmodule

/* rtl/wsd_checker.sv */
// Port-level checker for the websocket frame deframer, bound to its top level.
// Depends on websocket_frame_deframer only through its ports.
module wsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] text_byte_o,
  input logic       byte_valid_o,
  input logic       frame_end_o,
  input logic       close_seen_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(text_byte_o)
      && $stable(byte_valid_o) && $stable(frame_end_o) && $stable(close_seen_o))
    else $error("stalled result changed");

  a_close_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && close_seen_o |-> frame_end_o && !byte_valid_o)
    else $error("close indication without frame end or with data");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> frame_end_o && (text_byte_o == 8'd0))
    else $error("marker result carries data or no frame end");

  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rx_valid_i && !rx_stall_o, 2))
    else $error("result without a byte transfer two cycles earlier");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_valid_i   (rx_valid_i),
  .rx_stall_o   (rx_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .text_byte_o  (text_byte_o),
  .byte_valid_o (byte_valid_o),
  .frame_end_o  (frame_end_o),
  .close_seen_o (close_seen_o)
);

/* bench/websocket_frame_deframer_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_deframer: streams frames byte by byte.
// It predicts every deframed result and checks each out-channel transfer against it.
// Depends on wsd_pkg and the deframer RTL.
module websocket_frame_deframer_test;

  // Opcodes the package leaves out; the parser treats all of them as silent frames.
  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_PING   = 4'h9;

  localparam int unsigned RANDOM_BYTES = 950;
  localparam int unsigned QUIET_BYTES  = 150;   // tail of the random part with no gaps
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       close_seen;
  } deframe_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       rx_valid_i  = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] text_byte_o;
  logic       byte_valid_o;
  logic       frame_end_o;
  logic       close_seen_o;

  websocket_frame_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_byte_o (text_byte_o),
    .byte_valid_o(byte_valid_o),
    .frame_end_o (frame_end_o),
    .close_seen_o(close_seen_o)
  );

  always #6 clk_i = ~clk_i;

  // Bench bookkeeping.
  bit              gaps_on = 1'b1;
  int unsigned     rx_sent;
  int unsigned     mismatch_count;
  int unsigned     cycle_count;
  int unsigned     stall_left;
  logic [7:0]      wire_q[$];       // bytes of the frame being assembled
  deframe_result_t deframed_q[$];   // results still owed by the block, oldest first

  // Deframer state as the bench tracks it; these mirror the block's reset values.
  wsd_pkg::phase_e ws_phase    = wsd_pkg::PH_HDR0;
  logic [3:0]      ws_hdr_left = 4'd0;
  logic            ws_fin      = 1'b0;
  logic [3:0]      ws_opcode   = 4'h0;
  logic            ws_masked   = 1'b0;
  logic [63:0]     ws_left     = 64'd0;
  logic [31:0]     ws_key      = 32'd0;
  logic [1:0]      ws_key_idx  = 2'd0;

  // ---------------------------------------------------------------------------
  // Deframing prediction
  // ---------------------------------------------------------------------------
  function automatic void owe_result(logic [7:0] b, logic v, logic e, logic c);
    deframe_result_t r;
    r = '{text_byte: b, byte_valid: v, frame_end: e, close_seen: c};
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  // Frame fully consumed: a final text frame owes its end marker, a final close its
  // close indication.
  function automatic void finish_frame();
    ws_phase = wsd_pkg::PH_HDR0;
    if (ws_fin && ws_opcode == wsd_pkg::OPC_TEXT) begin
      owe_result(8'h00, 1'b0, 1'b1, 1'b0);
    end else if (ws_fin && ws_opcode == wsd_pkg::OPC_CLOSE) begin
      owe_result(8'h00, 1'b0, 1'b1, 1'b1);
    end
  endfunction

  function automatic void start_payload();
    ws_key_idx = 2'd0;
    if (ws_left == 64'd0) begin
      finish_frame();
    end else begin
      ws_phase = wsd_pkg::PH_PAYLOAD;
    end
  endfunction

  function automatic void length_known();
    if (ws_masked) begin
      ws_phase    = wsd_pkg::PH_MASK;
      ws_hdr_left = wsd_pkg::KEY_BYTES;
    end else begin
      start_payload();
    end
  endfunction

  // Advance the tracked parser by one accepted stream byte.
  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] key_byte;
    logic [7:0] plain;
    logic       last_byte;
    case (ws_phase)
      wsd_pkg::PH_HDR1: begin
        ws_masked = b[7];
        ws_left   = 64'd0;
        if (b[6:0] == wsd_pkg::LEN_EXT16) begin
          ws_phase    = wsd_pkg::PH_EXTLEN;
          ws_hdr_left = wsd_pkg::EXT16_BYTES;
        end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
          ws_phase    = wsd_pkg::PH_EXTLEN;
          ws_hdr_left = wsd_pkg::EXT64_BYTES;
        end else begin
          ws_left = 64'(b[6:0]);
          length_known();
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        // Big-endian length, most significant byte first on the wire.
        ws_left     = {ws_left[55:0], b};
        ws_hdr_left = ws_hdr_left - 4'd1;
        if (ws_hdr_left == 4'd0) length_known();
      end
      wsd_pkg::PH_MASK: begin
        // First key byte on the wire lands in bits 31..24.
        ws_key      = {ws_key[23:0], b};
        ws_hdr_left = ws_hdr_left - 4'd1;
        if (ws_hdr_left == 4'd0) start_payload();
      end
      wsd_pkg::PH_PAYLOAD: begin
        key_byte   = ws_key[8 * (3 - ws_key_idx) +: 8];
        plain      = b ^ key_byte;
        ws_left    = ws_left - 64'd1;
        ws_key_idx = ws_key_idx + 2'd1;
        last_byte  = (ws_left == 64'd0);
        if (last_byte) ws_phase = wsd_pkg::PH_HDR0;
        if (ws_fin && ws_opcode == wsd_pkg::OPC_TEXT) begin
          owe_result(plain, 1'b1, last_byte, 1'b0);
        end else if (last_byte && ws_fin && ws_opcode == wsd_pkg::OPC_CLOSE) begin
          owe_result(8'h00, 1'b0, 1'b1, 1'b1);
        end
      end
      default: begin
        ws_fin      = b[7];
        ws_opcode   = b[3:0];
        ws_masked   = 1'b0;
        ws_left     = 64'd0;
        ws_key      = 32'd0;
        ws_key_idx  = 2'd0;
        ws_hdr_left = 4'd0;
        ws_phase    = wsd_pkg::PH_HDR1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Append one byte to the frame being assembled.
  function automatic void queue_wire(logic [7:0] b);
    wire_q.insert(wire_q.size(), b);
  endfunction

  // Send one byte on the rx channel; predict it at the edge of its transfer.
  task automatic send_rx_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    // Hold the byte until the block takes it.
    while (rx_stall_o) @(posedge clk_i);
    deframe_byte(b);
    rx_sent++;
  endtask

  task automatic send_wire_bytes();
    while (wire_q.size() != 0) send_rx_byte(wire_q.pop_front());
  endtask

  // Queue a frame header: first byte with random reserved bits, length in the chosen
  // encoding, then the key if masked.
  function automatic void put_header(logic fin, logic [3:0] opc, logic masked,
                                     logic [63:0] len, len_enc_e enc, logic [31:0] key);
    queue_wire({fin, 3'($urandom), opc});
    case (enc)
      ENC_EXT16: begin
        queue_wire({masked, wsd_pkg::LEN_EXT16});
        queue_wire(len[15:8]);
        queue_wire(len[7:0]);
      end
      ENC_EXT64: begin
        queue_wire({masked, wsd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) queue_wire(len[8 * i +: 8]);
      end
      default: queue_wire({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) queue_wire(key[8 * i +: 8]);
    end
  endfunction

  // Byte that keeps a damaged stream bounded: never an open-ended 64-bit length, and
  // any extended length stays below 512, so the parser finds a frame edge soon.
  function automatic logic [7:0] filler_byte();
    case (ws_phase)
      wsd_pkg::PH_HDR1:   return {1'($urandom), 7'($urandom_range(0, 126))};
      wsd_pkg::PH_EXTLEN: begin
        if (ws_hdr_left > wsd_pkg::EXT16_BYTES) return 8'h00;
        if (ws_hdr_left == wsd_pkg::EXT16_BYTES) return 8'($urandom_range(0, 1));
        return 8'($urandom);
      end
      default:   return 8'($urandom);
    endcase
  endfunction

  // Feed filler until the parser is back at a frame boundary.
  task automatic resync_stream();
    while (ws_phase != wsd_pkg::PH_HDR0) send_rx_byte(filler_byte());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Final text frames, masked with extreme key bytes and unmasked.
  task automatic test_text_frames();
    put_header(1'b1, wsd_pkg::OPC_TEXT, 1'b1, 64'd2, ENC_SHORT, 32'hFF00_00FF);
    queue_wire(8'h00);
    queue_wire(8'hFF);
    put_header(1'b1, wsd_pkg::OPC_TEXT, 1'b0, 64'd2, ENC_SHORT, 32'h0);
    queue_wire(8'hFF);
    queue_wire(8'h00);
    send_wire_bytes();
  endtask

  // Empty text frame gives a bare end marker; close frames give the close indication.
  task automatic test_empty_and_close();
    put_header(1'b1, wsd_pkg::OPC_TEXT, 1'b0, 64'd0, ENC_SHORT, 32'h0);
    put_header(1'b1, wsd_pkg::OPC_CLOSE, 1'b1, 64'd1, ENC_SHORT, 32'h1234_5678);
    queue_wire(8'h5A);
    put_header(1'b1, wsd_pkg::OPC_CLOSE, 1'b0, 64'd0, ENC_SHORT, 32'h0);
    send_wire_bytes();
  endtask

  // Non-final text, binary with an empty 16-bit length, ping, masked continuation: all silent.
  task automatic test_silent_frames();
    put_header(1'b0, wsd_pkg::OPC_TEXT, 1'b0, 64'd0, ENC_SHORT, 32'h0);
    put_header(1'b1, OPC_BINARY, 1'b0, 64'd0, ENC_EXT16, 32'h0);
    put_header(1'b1, OPC_PING, 1'b0, 64'd1, ENC_SHORT, 32'h0);
    queue_wire(8'hC3);
    put_header(1'b0, OPC_CONT, 1'b1, 64'd0, ENC_SHORT, 32'hFFFF_FFFF);
    send_wire_bytes();
  endtask

  // Mostly well-formed frames with random content, some cut short, some raw noise.
  task automatic test_random_stream();
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    logic        fin;
    logic        masked;
    logic [3:0]  opc;
    logic [63:0] len;
    len_enc_e    enc;
    target = rx_sent + RANDOM_BYTES;
    while (rx_sent < target) begin
      if (rx_sent + QUIET_BYTES >= target) gaps_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(2, 12)) send_rx_byte(filler_byte());
      end else begin
        pick   = $urandom_range(0, 99);
        opc    = (pick < 50) ? wsd_pkg::OPC_TEXT :
                 (pick < 65) ? wsd_pkg::OPC_CLOSE : 4'($urandom);
        fin    = ($urandom_range(0, 7) != 0);
        masked = 1'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick < 70) len = 64'($urandom_range(0, 12));
        else if (pick < 93) len = 64'($urandom_range(13, 125));
        else len = 64'($urandom_range(126, 300));
        if (len > 64'd125 || $urandom_range(0, 9) >= 8) begin
          enc = $urandom_range(0, 1) ? ENC_EXT64 : ENC_EXT16;
        end else begin
          enc = ENC_SHORT;
        end
        put_header(fin, opc, masked, len, enc, $urandom);
        repeat (int'(len)) queue_wire(8'($urandom));
        // Drop the tail of some frames; the resync below completes them with filler.
        if ($urandom_range(0, 11) == 0) begin
          cut = $urandom_range(1, wire_q.size());
          while (wire_q.size() > cut) wire_q.delete(wire_q.size() - 1);
        end
        send_wire_bytes();
      end
      resync_stream();
    end
  endtask

  // A 64-bit length with its top bit set is taken as given; the frame never ends, so
  // run this last.
  task automatic test_top_bit_length();
    put_header(1'b1, wsd_pkg::OPC_TEXT, 1'b1, 64'h8000_0000_0000_0000, ENC_EXT64,
               $urandom);
    repeat (8) queue_wire(8'($urandom));
    send_wire_bytes();
  endtask

  // ---------------------------------------------------------------------------
  // Out channel: random stall bursts, none once gaps are switched off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!gaps_on || !rst_ni) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check every out-channel transfer against the oldest owed result.
  always @(posedge clk_i) begin : check_result
    deframe_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deframed_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transfer: byte %02h valid %0b end %0b close %0b",
                   text_byte_o, byte_valid_o, frame_end_o, close_seen_o);
        end
      end else begin
        want = deframed_q.pop_front();
        if (want.text_byte !== text_byte_o || want.byte_valid !== byte_valid_o ||
            want.frame_end !== frame_end_o || want.close_seen !== close_seen_o) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected byte %02h valid %0b end %0b close %0b",
                     want.text_byte, want.byte_valid, want.frame_end, want.close_seen);
            $display("          got      byte %02h valid %0b end %0b close %0b",
                     text_byte_o, byte_valid_o, frame_end_o, close_seen_o);
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_text_frames();
    test_empty_and_close();
    test_silent_frames();
    test_random_stream();
    test_top_bit_length();
    rx_valid_i <= 1'b0;
    // Drain owed results, then give the pipeline time to show any stray transfer.
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
